@@ sv/assert_macros.svh @@
// Assertion helpers for the normal-equation accumulator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clock edge, reset included.
`define P2PNA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// Check outside reset only.
`define P2PNA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

@@ sv/p2pna_pkg.sv @@
`default_nettype none
package p2pna_pkg;

    localparam int COORD_W     = 24;
    localparam int NORM_W      = 16;
    localparam int GAIN_IN_W   = 16;
    localparam int ACC_WIDTH   = 64;
    localparam int VALUE_W     = 64;
    localparam int NUM_A       = 21;
    localparam int NUM_ENTRIES = 27;
    localparam int IDX_W       = 5;
    localparam int ROW_W       = 3;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_ENTRIES - 1);
    localparam logic [IDX_W-1:0] FIRST_B   = IDX_W'(NUM_A);
    localparam logic [IDX_W-1:0] FIRST_IDX = '0;

    // Front-end widths
    localparam int CP_W  = COORD_W + NORM_W;          // one cross-product term
    localparam int CR_W  = CP_W + 1;                  // cross-product difference
    localparam int DP_W  = COORD_W + 1 + NORM_W;      // (p - q) * n
    localparam int DS_W  = DP_W + 2;                  // three-term dot product
    localparam int WK_W  = 2 * GAIN_IN_W;
    localparam int WKK_W = 3 * GAIN_IN_W + 1;
    localparam int FMAG_W = 27;                       // rounded magnitude of f and d
    localparam int G_W   = 19;                        // gain magnitude

    // Term widths
    localparam int XW     = FMAG_W + G_W;
    localparam int HALF   = XW / 2;
    localparam int PP_W   = (XW - HALF) + FMAG_W;
    localparam int PM_W   = XW + FMAG_W + 1;
    localparam int TMAG_W = PM_W - 15;
    localparam int CMP_W  = (TMAG_W > ACC_WIDTH) ? TMAG_W : ACC_WIDTH;

    localparam logic [ROW_W-1:0] ENTRY_ROW [NUM_ENTRIES] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd2, 3'd2, 3'd2, 3'd2,
        3'd3, 3'd3, 3'd3,
        3'd4, 3'd4,
        3'd5,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5
    };

    localparam logic [ROW_W-1:0] ENTRY_COL [NUM_ENTRIES] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
        3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
        3'd2, 3'd3, 3'd4, 3'd5,
        3'd3, 3'd4, 3'd5,
        3'd4, 3'd5,
        3'd5,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FRONT1,
        ST_FRONT2,
        ST_FRONT3,
        ST_TERM_MUL,
        ST_TERM_PART,
        ST_TERM_SUM,
        ST_TERM_ACC,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic             load;
        logic             acc_we;
        logic             emit_take;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic last;
    } stat_t;

endpackage
`default_nettype wire

@@ sv/p2pna_ctrl.sv @@
`default_nettype none
module p2pna_ctrl (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire                out_ready,
    input  p2pna_pkg::stat_t   stat,
    output p2pna_pkg::cmd_t    cmd
);
    import p2pna_pkg::*;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= FIRST_IDX;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_FRONT1;
            end
            ST_FRONT1:    state_next = ST_FRONT2;
            ST_FRONT2:    state_next = ST_FRONT3;
            ST_FRONT3:    state_next = ST_TERM_MUL;
            ST_TERM_MUL:  state_next = ST_TERM_PART;
            ST_TERM_PART: state_next = ST_TERM_SUM;
            ST_TERM_SUM:  state_next = ST_TERM_ACC;
            ST_TERM_ACC:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = FIRST_IDX;
                    state_next = stat.last ? ST_EMIT : ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_TERM_MUL;
                end
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_next   = FIRST_IDX;
                        state_next = ST_IDLE;
                    end
                    else
                        idx_next = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                idx_next   = FIRST_IDX;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE);
        out_valid     = (state_reg == ST_EMIT);
        cmd.load      = in_valid && (state_reg == ST_IDLE);
        cmd.acc_we    = (state_reg == ST_TERM_ACC);
        cmd.emit_take = (state_reg == ST_EMIT) && out_ready;
        cmd.idx       = idx_reg;
    end

endmodule
`default_nettype wire

@@ sv/p2pna_datapath.sv @@
`default_nettype none
module p2pna_datapath (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   cfg_write_en,
    input  wire                                   cfg_write_data,
    input  wire signed [p2pna_pkg::COORD_W-1:0]   src_x,
    input  wire signed [p2pna_pkg::COORD_W-1:0]   src_y,
    input  wire signed [p2pna_pkg::COORD_W-1:0]   src_z,
    input  wire signed [p2pna_pkg::COORD_W-1:0]   tgt_x,
    input  wire signed [p2pna_pkg::COORD_W-1:0]   tgt_y,
    input  wire signed [p2pna_pkg::COORD_W-1:0]   tgt_z,
    input  wire signed [p2pna_pkg::NORM_W-1:0]    norm_x,
    input  wire signed [p2pna_pkg::NORM_W-1:0]    norm_y,
    input  wire signed [p2pna_pkg::NORM_W-1:0]    norm_z,
    input  wire        [p2pna_pkg::GAIN_IN_W-1:0] weight,
    input  wire        [p2pna_pkg::GAIN_IN_W-1:0] comp_factor,
    input  wire                                   last_pair,
    input  p2pna_pkg::cmd_t                       cmd,
    output p2pna_pkg::stat_t                      stat,
    output logic       [p2pna_pkg::IDX_W-1:0]     entry_index,
    output logic signed [p2pna_pkg::VALUE_W-1:0]  entry_value,
    output logic                                  saturated,
    output logic                                  last_entry
);
    import p2pna_pkg::*;

    function automatic logic [FMAG_W-1:0] rnd14(input logic signed [DS_W-1:0] v);
        logic [DS_W-1:0] m;
        logic [DS_W-1:0] r;
        m = v[DS_W-1] ? DS_W'(-v) : DS_W'(v);
        r = (m + DS_W'(1 << 13)) >> 14;
        return r[FMAG_W-1:0];
    endfunction

    logic comp_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            comp_en_reg <= 1'b0;
        else if (cfg_write_en)
            comp_en_reg <= cfg_write_data;
    end

    // Captured pair
    logic signed [COORD_W-1:0] p_reg [3];
    logic signed [COORD_W-1:0] q_reg [3];
    logic signed [NORM_W-1:0]  n_reg [3];
    logic [GAIN_IN_W-1:0]      w_reg, k_reg;
    logic                      last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            p_reg[0] <= src_x;  p_reg[1] <= src_y;  p_reg[2] <= src_z;
            q_reg[0] <= tgt_x;  q_reg[1] <= tgt_y;  q_reg[2] <= tgt_z;
            n_reg[0] <= norm_x; n_reg[1] <= norm_y; n_reg[2] <= norm_z;
            w_reg    <= weight;
            k_reg    <= comp_factor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_reg <= 1'b0;
        else if (cmd.load)
            last_reg <= last_pair;
    end

    assign stat.last = last_reg;

    // Front stage 1: lane products
    logic signed [CP_W-1:0] cp_reg [6];
    logic signed [DP_W-1:0] dp_reg [3];
    logic [WK_W-1:0]        wk_reg;

    always_ff @(posedge clk)
    begin
        cp_reg[0] <= CP_W'(p_reg[1]) * CP_W'(n_reg[2]);
        cp_reg[1] <= CP_W'(p_reg[2]) * CP_W'(n_reg[1]);
        cp_reg[2] <= CP_W'(p_reg[2]) * CP_W'(n_reg[0]);
        cp_reg[3] <= CP_W'(p_reg[0]) * CP_W'(n_reg[2]);
        cp_reg[4] <= CP_W'(p_reg[0]) * CP_W'(n_reg[1]);
        cp_reg[5] <= CP_W'(p_reg[1]) * CP_W'(n_reg[0]);
        for (int i = 0; i < 3; i++)
            dp_reg[i] <= (DP_W'(p_reg[i]) - DP_W'(q_reg[i])) * DP_W'(n_reg[i]);
        wk_reg <= WK_W'(w_reg) * WK_W'(k_reg);
    end

    // Front stage 2: differences, dot sum, gain products
    logic signed [CR_W-1:0] cr_reg [3];
    logic signed [DS_W-1:0] ds_reg;
    logic [WKK_W-1:0]       wkk_reg;
    logic [G_W-1:0]         gb_raw_reg;
    logic [WK_W:0]          gb_sum;

    assign gb_sum = (WK_W+1)'(wk_reg) + (WK_W+1)'(1 << 14);

    always_ff @(posedge clk)
    begin
        cr_reg[0]  <= CR_W'(cp_reg[0]) - CR_W'(cp_reg[1]);
        cr_reg[1]  <= CR_W'(cp_reg[2]) - CR_W'(cp_reg[3]);
        cr_reg[2]  <= CR_W'(cp_reg[4]) - CR_W'(cp_reg[5]);
        ds_reg     <= DS_W'(dp_reg[0]) + DS_W'(dp_reg[1]) + DS_W'(dp_reg[2]);
        wkk_reg    <= WKK_W'(wk_reg) * WKK_W'(k_reg);
        gb_raw_reg <= G_W'(gb_sum[WK_W:15]);
    end

    // Front stage 3: f and d to magnitude and sign (cross products and d rounded), pick gains
    logic [FMAG_W-1:0] fmag_reg [6];
    logic              fneg_reg [6];
    logic [FMAG_W-1:0] dmag_reg;
    logic              dneg_reg;
    logic [G_W-1:0]    ga_reg, gb_reg;
    logic [WKK_W-1:0]  ga_sum;

    assign ga_sum = wkk_reg + WKK_W'(1 << 29);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            fmag_reg[i]     <= rnd14(DS_W'(cr_reg[i]));
            fneg_reg[i]     <= cr_reg[i][CR_W-1];
            // Magnitude as unsigned, so the most negative normal reads as 2^15
            fmag_reg[i + 3] <= FMAG_W'($unsigned(n_reg[i][NORM_W-1] ? -n_reg[i]
                                                                    : n_reg[i]));
            fneg_reg[i + 3] <= n_reg[i][NORM_W-1];
        end
        dmag_reg <= rnd14(ds_reg);
        dneg_reg <= ds_reg[DS_W-1];
        ga_reg   <= comp_en_reg ? G_W'(ga_sum[WKK_W-1:30]) : G_W'(w_reg);
        gb_reg   <= comp_en_reg ? gb_raw_reg : G_W'(w_reg);
    end

    // Term path, one entry at a time
    logic [IDX_W-1:0]  e;
    logic [ROW_W-1:0]  row, col;
    logic              is_b;
    logic [FMAG_W-1:0] a_mag, b_mag;
    logic [G_W-1:0]    g_sel;
    logic              t_neg;

    assign e     = cmd.idx;
    assign row   = ENTRY_ROW[e];
    assign col   = ENTRY_COL[e];
    assign is_b  = (e >= FIRST_B);
    assign a_mag = fmag_reg[row];
    assign b_mag = is_b ? dmag_reg : fmag_reg[col];
    assign g_sel = is_b ? gb_reg : ga_reg;
    assign t_neg = fneg_reg[row] ^ (is_b ? dneg_reg : fneg_reg[col]) ^ is_b;

    logic [XW-1:0]   x_reg;
    logic [PP_W-1:0] pl_reg, ph_reg;

    always_ff @(posedge clk)
    begin
        x_reg  <= XW'(a_mag) * XW'(g_sel);
        pl_reg <= PP_W'(x_reg[HALF-1:0]) * PP_W'(b_mag);
        ph_reg <= PP_W'(x_reg[XW-1:HALF]) * PP_W'(b_mag);
    end

    logic [PM_W-1:0]                full;
    logic [CMP_W-1:0]               tmag, lim, mag_c;
    logic signed [ACC_WIDTH-1:0]    term_reg;
    logic                           term_sat_reg;

    always_comb
    begin
        full  = (PM_W'(ph_reg) << HALF) + PM_W'(pl_reg) + PM_W'(1 << 14);
        tmag  = CMP_W'(full[PM_W-1:15]);
        lim   = t_neg ? (CMP_W'(1) << (ACC_WIDTH - 1))
                      : ((CMP_W'(1) << (ACC_WIDTH - 1)) - CMP_W'(1));
        mag_c = (tmag > lim) ? lim : tmag;
    end

    always_ff @(posedge clk)
    begin
        term_reg     <= t_neg ? -mag_c[ACC_WIDTH-1:0] : mag_c[ACC_WIDTH-1:0];
        term_sat_reg <= (tmag > lim);
    end

    // Accumulator store
    logic signed [ACC_WIDTH-1:0] acc_reg [NUM_ENTRIES];
    logic                        sat_reg [NUM_ENTRIES];
    logic signed [ACC_WIDTH:0]   sum;
    logic                        ovf;
    logic signed [ACC_WIDTH-1:0] sum_c;

    always_comb
    begin
        sum   = (ACC_WIDTH+1)'(acc_reg[e]) + (ACC_WIDTH+1)'(term_reg);
        ovf   = (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]);
        sum_c = sum[ACC_WIDTH-1:0];
        if (ovf)
            sum_c = sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                   : {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                acc_reg[i] <= '0;
                sat_reg[i] <= 1'b0;
            end
        end
        else if (cmd.acc_we)
        begin
            acc_reg[e] <= sum_c;
            sat_reg[e] <= sat_reg[e] | term_sat_reg | ovf;
        end
        else if (cmd.emit_take)
        begin
            acc_reg[e] <= '0;
            sat_reg[e] <= 1'b0;
        end
    end

    assign entry_index = e;
    assign entry_value = VALUE_W'(acc_reg[e]);
    assign saturated   = sat_reg[e];
    assign last_entry  = (e == LAST_IDX);

endmodule
`default_nettype wire

@@ sv/point_to_plane_normal_accumulator.sv @@
`default_nettype none
`include "assert_macros.svh"
// Point-to-plane normal-equation accumulator. Each transfer on the input
// channel is one matched pair (source point, target point, target normal,
// weight, compensation factor); the block adds its contribution to the 21
// upper-triangle sums of A and the 6 sums of b, all saturating. A pair with
// last_pair set is accumulated first, then the 27 sums go out as 27 output
// transfers (A row-major as entries 0..20, b as 21..26, last_entry on 26),
// and each sum clears as it is transferred. A pair goes through capture, the
// front-end states for f, d and the gains, then for each of the 27 entries
// in turn the multiply, partial, sum and accumulate states of the shared term
// multipliers and accumulator adder. While results are being emitted no
// new pair is taken. Write compensation_enable only while the block is idle.
module point_to_plane_normal_accumulator (
    input  wire                                   clk,
    input  wire                                   rst_n,
    // configuration
    input  wire                                   cfg_write_en,
    input  wire                                   cfg_write_data,
    // pair input
    input  wire                                   in_valid,
    output logic                                  in_ready,
    input  wire signed [p2pna_pkg::COORD_W-1:0]   src_x,
    input  wire signed [p2pna_pkg::COORD_W-1:0]   src_y,
    input  wire signed [p2pna_pkg::COORD_W-1:0]   src_z,
    input  wire signed [p2pna_pkg::COORD_W-1:0]   tgt_x,
    input  wire signed [p2pna_pkg::COORD_W-1:0]   tgt_y,
    input  wire signed [p2pna_pkg::COORD_W-1:0]   tgt_z,
    input  wire signed [p2pna_pkg::NORM_W-1:0]    norm_x,
    input  wire signed [p2pna_pkg::NORM_W-1:0]    norm_y,
    input  wire signed [p2pna_pkg::NORM_W-1:0]    norm_z,
    input  wire        [p2pna_pkg::GAIN_IN_W-1:0] weight,
    input  wire        [p2pna_pkg::GAIN_IN_W-1:0] comp_factor,
    input  wire                                   last_pair,
    // sum output
    output logic                                  out_valid,
    input  wire                                   out_ready,
    output logic       [p2pna_pkg::IDX_W-1:0]     entry_index,
    output logic signed [p2pna_pkg::VALUE_W-1:0]  entry_value,
    output logic                                  saturated,
    output logic                                  last_entry
);
    import p2pna_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequence the pair: capture, front end, per-entry term loop, emission.
    p2pna_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Arithmetic and the 27-entry store.
    p2pna_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .src_x          (src_x),
        .src_y          (src_y),
        .src_z          (src_z),
        .tgt_x          (tgt_x),
        .tgt_y          (tgt_y),
        .tgt_z          (tgt_z),
        .norm_x         (norm_x),
        .norm_y         (norm_y),
        .norm_z         (norm_z),
        .weight         (weight),
        .comp_factor    (comp_factor),
        .last_pair      (last_pair),
        .cmd            (cmd),
        .stat           (stat),
        .entry_index    (entry_index),
        .entry_value    (entry_value),
        .saturated      (saturated),
        .last_entry     (last_entry)
    );

    // Emission and intake never overlap.
    `P2PNA_ASSERT_ALWAYS(a_no_overlap, !(out_valid && in_ready), "intake during emission")
    // The last flag marks exactly the final entry.
    `P2PNA_ASSERT(a_last_flag, out_valid |-> (last_entry == (entry_index == LAST_IDX)), "last_entry mismatch")
    // Emission stops after the final entry transfers.
    `P2PNA_ASSERT(a_emit_end, (out_valid && out_ready && last_entry) |=> !out_valid, "emission overran")
    // Emission starts at the first entry.
    `P2PNA_ASSERT(a_emit_start, $rose(out_valid) |-> (entry_index == FIRST_IDX), "emission not at entry 0")

endmodule
`default_nettype wire

@@ tb/sv/point_to_plane_normal_accumulator_tb.sv @@
`timescale 1ns / 1ps
module point_to_plane_normal_accumulator_tb;
    import p2pna_pkg::*;

    localparam int NUM_B      = NUM_ENTRIES - NUM_A;
    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE     = 150;
    localparam int LONG_HOLD  = 300;
    localparam int EXTREME_PAIRS = 40;

    localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [NORM_W-1:0]  N_MAX = 16'sh7fff;
    localparam logic signed [NORM_W-1:0]  N_MIN = -16'sh8000;
    localparam logic signed [63:0] SUM_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx, sy, sz, tx, ty, tz;
        logic signed [NORM_W-1:0]  nx, ny, nz;
        logic [GAIN_IN_W-1:0]      w, k;
        logic                      last;
    } pair_t;

    typedef struct packed {
        logic [IDX_W-1:0]          idx;
        logic signed [VALUE_W-1:0] value;
        logic                      sat;
        logic                      last;
    } entry_t;

    // Directed row: compensation setting, the pair, and whether the emitted
    // sums are known to be all zero.
    typedef struct packed {
        logic  comp;
        pair_t pair;
        logic  zero_sums;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic cfg_write_data;
    logic in_valid;
    logic in_ready;
    pair_t drv;
    logic out_valid;
    logic out_ready;
    logic [IDX_W-1:0] entry_index;
    logic signed [VALUE_W-1:0] entry_value;
    logic saturated;
    logic last_entry;

    // Predictor state
    logic signed [63:0] a_sums [NUM_A];
    logic signed [63:0] b_sums [NUM_B];
    bit                 sat_marks [NUM_ENTRIES];
    bit                 comp_on;

    entry_t sums_q[$];
    int     errors;
    int     entries_seen;
    int     idle_cycles;
    bit     quiet;

    point_to_plane_normal_accumulator u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .src_x          (drv.sx),
        .src_y          (drv.sy),
        .src_z          (drv.sz),
        .tgt_x          (drv.tx),
        .tgt_y          (drv.ty),
        .tgt_z          (drv.tz),
        .norm_x         (drv.nx),
        .norm_y         (drv.ny),
        .norm_z         (drv.nz),
        .weight         (drv.w),
        .comp_factor    (drv.k),
        .last_pair      (drv.last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .entry_index    (entry_index),
        .entry_value    (entry_value),
        .saturated      (saturated),
        .last_entry     (last_entry)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Divide by 2^14, magnitude rounded half away from zero.
    function automatic logic signed [63:0] round14(input logic signed [63:0] v);
        logic [63:0] m;
        m = v < 0 ? -v : v;
        m = (m + 64'd8192) >> 14;
        return v < 0 ? -$signed(m) : $signed(m);
    endfunction

    // round(g*a*b / 2^15), sign flipped for the right-hand side, clipped.
    function automatic logic signed [63:0] gain_term(input logic [63:0] g,
            input logic signed [63:0] a, input logic signed [63:0] b,
            input bit flip, inout bit sat);
        logic [127:0] ma, mb, m, lim;
        bit negative;
        negative = ((a < 0) != (b < 0)) != flip;
        ma = a < 0 ? 128'(-a) : 128'(a);
        mb = b < 0 ? 128'(-b) : 128'(b);
        m = (ma * mb * 128'(g) + 128'd16384) >> 15;
        lim = negative ? (128'd1 << 63) : ((128'd1 << 63) - 1);
        if (m > lim)
        begin
            sat = 1'b1;
            m = lim;
        end
        return negative ? -$signed(m[63:0]) : $signed(m[63:0]);
    endfunction

    function automatic logic signed [63:0] clip_add(input logic signed [63:0] acc,
            input logic signed [63:0] t, inout bit sat);
        logic signed [64:0] s;
        s = 65'(acc) + 65'(t);
        if (s > 65'(SUM_MAX))
        begin
            sat = 1'b1;
            return SUM_MAX;
        end
        if (s < 65'(SUM_MIN))
        begin
            sat = 1'b1;
            return SUM_MIN;
        end
        return s[63:0];
    endfunction

    // Fold one pair into the sums; on the last pair queue the 27 results
    // (typed as zero when the row says so) and clear.
    task automatic accumulate_pair(input pair_t p, input bit zero_sums);
        logic signed [63:0] pv [3];
        logic signed [63:0] nv [3];
        logic signed [63:0] f [6];
        logic signed [63:0] d;
        logic signed [63:0] t;
        logic [63:0] g_a, g_b;
        entry_t r;
        int e;
        bit s;
        pv[0] = p.sx; pv[1] = p.sy; pv[2] = p.sz;
        nv[0] = p.nx; nv[1] = p.ny; nv[2] = p.nz;
        f[0] = round14(pv[1] * nv[2] - pv[2] * nv[1]);
        f[1] = round14(pv[2] * nv[0] - pv[0] * nv[2]);
        f[2] = round14(pv[0] * nv[1] - pv[1] * nv[0]);
        f[3] = nv[0]; f[4] = nv[1]; f[5] = nv[2];
        d = round14((pv[0] - 64'(p.tx)) * nv[0] + (pv[1] - 64'(p.ty)) * nv[1]
                    + (pv[2] - 64'(p.tz)) * nv[2]);
        if (comp_on)
        begin
            g_a = (64'(p.w) * 64'(p.k) * 64'(p.k) + (64'd1 << 29)) >> 30;
            g_b = (64'(p.w) * 64'(p.k) + (64'd1 << 14)) >> 15;
        end
        else
        begin
            g_a = 64'(p.w);
            g_b = 64'(p.w);
        end
        e = 0;
        for (int i = 0; i < 6; i++)
            for (int j = i; j < 6; j++)
            begin
                s = 1'b0;
                t = gain_term(g_a, f[i], f[j], 1'b0, s);
                a_sums[e] = clip_add(a_sums[e], t, s);
                if (s)
                    sat_marks[e] = 1'b1;
                e++;
            end
        for (int i = 0; i < NUM_B; i++)
        begin
            s = 1'b0;
            t = gain_term(g_b, f[i], d, 1'b1, s);
            b_sums[i] = clip_add(b_sums[i], t, s);
            if (s)
                sat_marks[NUM_A + i] = 1'b1;
        end
        if (!p.last)
            return;
        for (e = 0; e < NUM_ENTRIES; e++)
        begin
            r.idx   = IDX_W'(e);
            r.value = zero_sums ? '0 : (e < NUM_A ? a_sums[e] : b_sums[e - NUM_A]);
            r.sat   = zero_sums ? 1'b0 : sat_marks[e];
            r.last  = (r.idx == LAST_IDX);
            sums_q = {sums_q, r};
            sat_marks[e] = 1'b0;
            if (e < NUM_A)
                a_sums[e] = '0;
            else
                b_sums[e - NUM_A] = '0;
        end
    endtask

    // Offer one pair starting at a falling edge; return at a falling edge.
    task automatic send_pair(input pair_t p, input bit zero_sums);
        if (!quiet && $urandom_range(0, 2) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        drv      <= p;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        accumulate_pair(p, zero_sums);
        @(negedge clk);
    endtask

    // Wait out every result, then the block's own time, then write the register.
    task automatic drain_and_set(input bit comp);
        in_valid <= 1'b0;
        wait (sums_q.size() == 0);
        repeat (SETTLE) @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= comp;
        comp_on = comp;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return C_MAX;
            1: return C_MIN;
            2: return '0;
            3, 4: return COORD_W'($signed($urandom_range(0, 2000)) - 1000);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [NORM_W-1:0] pick_norm();
        case ($urandom_range(0, 6))
            0: return N_MAX;
            1: return N_MIN;
            2: return '0;
            default: return NORM_W'($urandom);
        endcase
    endfunction

    function automatic logic [GAIN_IN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 16'd32768;
            1: return 16'hffff;
            2: return '0;
            3: return GAIN_IN_W'($urandom);
            default: return GAIN_IN_W'($urandom_range(0, 32768));
        endcase
    endfunction

    // Random sets of 1..8 pairs; the final pair of each set carries last_pair.
    task automatic send_random_sets(input int n_items);
        pair_t p;
        int left, set_len;
        left = n_items;
        while (left > 0)
        begin
            set_len = $urandom_range(1, 8);
            for (int i = 0; i < set_len; i++)
            begin
                p.sx = pick_coord(); p.sy = pick_coord(); p.sz = pick_coord();
                p.tx = pick_coord(); p.ty = pick_coord(); p.tz = pick_coord();
                p.nx = pick_norm();  p.ny = pick_norm();  p.nz = pick_norm();
                p.w = pick_gain();
                p.k = pick_gain();
                p.last = (i == set_len - 1);
                send_pair(p, 1'b0);
            end
            left -= set_len;
        end
    endtask

    // Directed table; rows switch the compensation setting where needed.
    row_t dir_rows [10] = '{
        '{1'b0, '{'0, '0, '0, '0, '0, '0, '0, '0, '0, 16'd0, 16'd0, 1'b1}, 1'b1},
        '{1'b0, '{C_MAX, '0, '0, '0, '0, '0, '0, 16'sd16384, '0,
                  16'd32768, 16'd0, 1'b0}, 1'b0},
        '{1'b0, '{C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, N_MIN, N_MIN, N_MIN,
                  16'hffff, 16'd0, 1'b0}, 1'b0},
        '{1'b0, '{24'sd1000, -24'sd2000, 24'sd3000, -24'sd5, 24'sd7, 24'sd9,
                  N_MAX, N_MAX, N_MAX, 16'd12345, 16'd0, 1'b1}, 1'b0},
        '{1'b0, '{'0, '0, '0, '0, '0, '0, '0, '0, '0, 16'hffff, 16'hffff, 1'b1}, 1'b1},
        '{1'b1, '{C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, N_MAX, N_MIN, N_MAX,
                  16'd32768, 16'd0, 1'b1}, 1'b1},
        '{1'b1, '{C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, N_MIN, N_MAX, N_MIN,
                  16'hffff, 16'hffff, 1'b0}, 1'b0},
        '{1'b1, '{-24'sd1, 24'sd1, -24'sd1, 24'sd1, -24'sd1, 24'sd1,
                  16'sd1, -16'sd1, 16'sd1, 16'd32768, 16'd32768, 1'b0}, 1'b0},
        '{1'b1, '{24'sd4096, -24'sd4096, 24'sd8192, '0, '0, '0, '0, '0, 16'sd16384,
                  16'd40000, 16'd50000, 1'b1}, 1'b0},
        '{1'b0, '{C_MAX, C_MIN, C_MAX, '0, '0, '0, N_MIN, N_MAX, N_MIN,
                  16'hffff, 16'hffff, 1'b1}, 1'b0}
    };

    // Sender / main sequence
    initial
    begin
        pair_t sat_pair;
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = 1'b0;
        in_valid       = 1'b0;
        drv            = '0;
        quiet          = 1'b0;
        errors         = 0;
        comp_on        = 1'b0;
        for (int e = 0; e < NUM_ENTRIES; e++)
            sat_marks[e] = 1'b0;
        for (int e = 0; e < NUM_A; e++)
            a_sums[e] = '0;
        for (int e = 0; e < NUM_B; e++)
            b_sums[e] = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Write the register once right after reset, even at its reset value.
        drain_and_set(1'b0);
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].comp != comp_on)
                drain_and_set(dir_rows[i].comp);
            send_pair(dir_rows[i].pair, dir_rows[i].zero_sums);
        end

        drain_and_set(1'b0);
        send_random_sets(60);

        // Pile up extreme pairs with full gain to push the sums toward their
        // largest magnitudes.
        drain_and_set(1'b1);
        sat_pair = '{C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, N_MIN, N_MAX, N_MIN,
                     16'hffff, 16'hffff, 1'b0};
        for (int i = 0; i < EXTREME_PAIRS; i++)
        begin
            sat_pair.last = (i == EXTREME_PAIRS - 1);
            send_pair(sat_pair, 1'b0);
        end
        send_random_sets(40);

        // Final part without idling on either side.
        drain_and_set(1'b0);
        quiet = 1'b1;
        send_random_sets(30);

        in_valid <= 1'b0;
        wait (sums_q.size() == 0);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("[point_to_plane_normal_accumulator] OK");
        else
            $display("[point_to_plane_normal_accumulator] ERROR");
        $finish;
    end

    // Receiver: random stalls, one long hold once 200 entries have been seen,
    // no random stalls in the quiet part.
    initial
    begin
        bit held;
        held = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && entries_seen >= 200)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                out_ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Checker and watchdog, sampled at the rising edge.
    initial
    begin
        entry_t exp_e;
        entries_seen = 0;
        idle_cycles  = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                entries_seen++;
                if (sums_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected entry idx=%0d value=%0d", $time,
                             entry_index, entry_value);
                end
                else
                begin
                    exp_e = sums_q.pop_front();
                    if (entry_index !== exp_e.idx)
                    begin
                        errors++;
                        $display("%0t: entry_index expected %0d actual %0d", $time,
                                 exp_e.idx, entry_index);
                    end
                    if (entry_value !== exp_e.value)
                    begin
                        errors++;
                        $display("%0t: entry %0d value expected %0d actual %0d", $time,
                                 exp_e.idx, exp_e.value, entry_value);
                    end
                    if (saturated !== exp_e.sat)
                    begin
                        errors++;
                        $display("%0t: entry %0d saturated expected %0b actual %0b",
                                 $time, exp_e.idx, exp_e.sat, saturated);
                    end
                    if (last_entry !== exp_e.last)
                    begin
                        errors++;
                        $display("%0t: entry %0d last_entry expected %0b actual %0b",
                                 $time, exp_e.idx, exp_e.last, last_entry);
                    end
                end
            end
            // Count cycles with no transfer on either channel.
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: timeout, %0d entries still expected", $time,
                         sums_q.size());
                $display("[point_to_plane_normal_accumulator] ERROR");
                $finish;
            end
        end
    end

endmodule

@@ files.f @@
+incdir+sv
sv/p2pna_pkg.sv
sv/p2pna_ctrl.sv
sv/p2pna_datapath.sv
sv/point_to_plane_normal_accumulator.sv
tb/sv/point_to_plane_normal_accumulator_tb.sv
